@@ design/cgc_pkg.sv @@
`timescale 1ns / 1ps

package cgc_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int DEG_CFG_W  = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_DEGREE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] GEN_POLY_RESET   = 32'h04C1_1DB7;
    localparam logic [DEG_CFG_W-1:0]  CRC_DEGREE_RESET = 6'd32;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    // Control part of one queued job; the remainder snapshot travels beside it.
    typedef struct packed {
        logic data_bit;
        logic is_check;
        logic is_final;
        logic err;
    } t_job_ctl;

    localparam int JOB_CTL_W = $bits(t_job_ctl);

endpackage

@@ design/cgc_front.sv @@
`timescale 1ns / 1ps

module cgc_front #(
    parameter int MAX_DEGREE = 32,
    parameter int DW         = 6,
    parameter int IW         = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_data_bit,
    input  logic                      i_mode,
    input  logic                      i_frame_end,
    input  logic [MAX_DEGREE-1:0]     i_poly,
    input  logic [DW-1:0]             i_deg,
    output logic                      o_enq,
    output cgc_pkg::t_job_ctl         o_ctl,
    output logic [MAX_DEGREE-1:0]     o_rem
);
    import cgc_pkg::*;

    logic [MAX_DEGREE-1:0] r_rem;
    logic [MAX_DEGREE-1:0] n_rem;
    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] rem_m;
    logic [MAX_DEGREE-1:0] shifted;
    logic                  top;
    logic                  fb;
    logic                  is_check;

    always_comb begin
        for (int k = 0; k < MAX_DEGREE; k++) begin
            mask[k] = (k < int'(i_deg));
        end
    end

    assign is_check = (i_mode == MODE_CHECK);
    assign rem_m    = r_rem & mask;
    assign top      = rem_m[IW'(i_deg - DW'(1))];
    // In check mode the incoming bit enters at the bottom; in encode mode it
    // is folded into the feedback instead.
    assign shifted  = ((rem_m << 1) | MAX_DEGREE'(is_check & i_data_bit)) & mask;
    assign fb       = is_check ? top : (top ^ i_data_bit);
    assign n_rem    = fb ? (shifted ^ (i_poly & mask)) : shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_accept) begin
            r_rem <= i_frame_end ? '0 : n_rem;
        end
    end

    // A check-mode bit that does not close the frame produces no result.
    assign o_enq          = i_accept && !(is_check && !i_frame_end);
    assign o_ctl.data_bit = i_data_bit;
    assign o_ctl.is_check = is_check;
    assign o_ctl.is_final = i_frame_end;
    assign o_ctl.err      = (n_rem != '0);
    assign o_rem          = n_rem;

endmodule

@@ design/cgc_queue.sv @@
`timescale 1ns / 1ps

module cgc_queue #(
    parameter int WIDTH = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import cgc_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

@@ design/cgc_back.sv @@
`timescale 1ns / 1ps

module cgc_back #(
    parameter int MAX_DEGREE = 32,
    parameter int DW         = 6,
    parameter int IW         = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  cgc_pkg::t_job_ctl     i_q_ctl,
    input  logic [MAX_DEGREE-1:0] i_q_rem,
    input  logic [DW-1:0]         i_deg,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_code_bit,
    output logic                  o_is_remainder,
    output logic                  o_error_found,
    output logic                  o_run_last
);
    import cgc_pkg::*;

    logic          r_out_valid;
    logic          r_code_bit;
    logic          r_is_rem;
    logic          r_err;
    logic          r_last;
    logic [DW-1:0] r_idx;
    logic [DW-1:0] n_idx;

    logic          load;
    logic          res_code;
    logic          res_is_rem;
    logic          res_err;
    logic          res_last;
    logic          done;

    assign load = i_q_valid && (!r_out_valid || i_out_ready);

    // Position 0 is the pass-through bit or the verdict; positions 1 to d
    // walk the remainder from its most significant bit down.
    always_comb begin
        res_code   = 1'b0;
        res_is_rem = 1'b0;
        res_err    = 1'b0;
        res_last   = 1'b1;
        done       = 1'b1;
        n_idx      = '0;
        if (i_q_ctl.is_check) begin
            res_err = i_q_ctl.err;
        end else if (r_idx == '0) begin
            res_code = i_q_ctl.data_bit;
            res_last = !i_q_ctl.is_final;
            done     = !i_q_ctl.is_final;
            n_idx    = i_q_ctl.is_final ? DW'(1) : '0;
        end else begin
            res_code   = i_q_rem[IW'(i_deg - r_idx)];
            res_is_rem = 1'b1;
            res_last   = (r_idx == i_deg);
            done       = res_last;
            n_idx      = res_last ? '0 : r_idx + DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= n_idx;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code_bit <= res_code;
            r_is_rem   <= res_is_rem;
            r_err      <= res_err;
            r_last     <= res_last;
        end
    end

    assign o_pop          = load && done;
    assign o_out_valid    = r_out_valid;
    assign o_code_bit     = r_code_bit;
    assign o_is_remainder = r_is_rem;
    assign o_error_found  = r_err;
    assign o_run_last     = r_last;

endmodule

@@ design/crc_codeword_generate_check_core.sv @@
`timescale 1ns / 1ps

// Serial CRC codeword generator and checker with a programmable generator.
// Input channel (i_in_valid / o_in_ready) takes one bit per item with its mode
// and a frame_end flag; output channel (o_out_valid / i_out_ready) gives one
// result item per cycle while i_out_ready is high. The front keeps the
// running remainder and does one shift-and-xor per item; a two-entry job
// queue feeds the back, which owns the output register and walks the
// appended remainder bits. Throughput: one input item per cycle while the
// job queue is not full. An encode frame end produces 1 + d result items,
// one per cycle from the output register while i_out_ready is high, so the
// input stalls once the job queue is full. A check bit that is not the last
// of its frame produces nothing. The first result of an item is registered
// in the job queue and then in the output register before it is offered.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) is to be written only while idle
// by the user (not enforced by the block): index 0 is the generator, index 1 the degree.
// Reset clears the remainder, the queue and the output register, and loads
// the generator 0x04C11DB7 with degree 32. When the receiver stalls, the
// current result holds, the queue fills, and then o_in_ready drops.
module crc_codeword_generate_check_core #(
    parameter int MAX_DEGREE = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cgc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cgc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_data_bit,
    input  logic                           i_mode,
    input  logic                           i_frame_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_code_bit,
    output logic                           o_is_remainder,
    output logic                           o_error_found,
    output logic                           o_run_last
);
    import cgc_pkg::*;

    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int QW = JOB_CTL_W + MAX_DEGREE;

    logic [CFG_DATA_W-1:0] r_gen_poly;
    logic [DEG_CFG_W-1:0]  r_crc_degree;
    logic [DW-1:0]         eff_deg;
    logic [MAX_DEGREE-1:0] poly;

    logic                  accept;
    logic                  enq;
    t_job_ctl              f_ctl;
    logic [MAX_DEGREE-1:0] f_rem;
    logic                  q_full;
    logic                  q_valid;
    logic [QW-1:0]         q_data;
    logic                  pop;
    t_job_ctl              q_ctl;
    logic [MAX_DEGREE-1:0] q_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_poly   <= GEN_POLY_RESET;
            r_crc_degree <= CRC_DEGREE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GEN_POLY:   r_gen_poly   <= i_cfg_data;
                REG_CRC_DEGREE: r_crc_degree <= i_cfg_data[DEG_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // A degree of zero acts as one; anything above the maximum is clamped.
    always_comb begin
        if (r_crc_degree == '0) begin
            eff_deg = DW'(1);
        end else if (int'(r_crc_degree) > MAX_DEGREE) begin
            eff_deg = DW'(MAX_DEGREE);
        end else begin
            eff_deg = DW'(r_crc_degree);
        end
    end

    assign poly       = MAX_DEGREE'(r_gen_poly);
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && !q_full;

    cgc_front #(
        .MAX_DEGREE (MAX_DEGREE),
        .DW         (DW),
        .IW         (IW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_bit  (i_data_bit),
        .i_mode      (i_mode),
        .i_frame_end (i_frame_end),
        .i_poly      (poly),
        .i_deg       (eff_deg),
        .o_enq       (enq),
        .o_ctl       (f_ctl),
        .o_rem       (f_rem)
    );

    cgc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enq),
        .i_data  ({f_ctl, f_rem}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_ctl = q_data[QW-1:MAX_DEGREE];
    assign q_rem = q_data[MAX_DEGREE-1:0];

    cgc_back #(
        .MAX_DEGREE (MAX_DEGREE),
        .DW         (DW),
        .IW         (IW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_ctl        (q_ctl),
        .i_q_rem        (q_rem),
        .i_deg          (eff_deg),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_code_bit     (o_code_bit),
        .o_is_remainder (o_is_remainder),
        .o_error_found  (o_error_found),
        .o_run_last     (o_run_last)
    );

    // A verdict is never mixed with remainder bits.
    a_err_not_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_error_found && o_is_remainder))
        else $error("error flag on a remainder bit");

    // A check verdict closes its run and carries no code bit.
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_found) |-> (o_run_last && !o_code_bit))
        else $error("check verdict malformed");

    // After a frame's final data bit, the remainder run must follow.
    a_rem_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_is_remainder && !o_run_last)
            |=> (o_out_valid && o_is_remainder))
        else $error("remainder run missing after final data bit");

endmodule
